/* hdl/pwm_motif_scanner_core_defines.svh */
// Assertion macros for the motif scanner.
`ifndef PWM_MOTIF_SCANNER_CORE_DEFINES_SVH
`define PWM_MOTIF_SCANNER_CORE_DEFINES_SVH

// check a same-cycle implication on the core clock
`define PMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a next-cycle implication on the core clock
`define PMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pms_pkg.sv */
// Shared constants and types of the motif scanner.
`timescale 1ns / 1ps
package pms_pkg;

  localparam int unsigned MAX_MOTIF_DEF  = 32;
  localparam int unsigned INDEX_BITS_DEF = 20;

  localparam int unsigned COST_W  = 16;
  localparam int unsigned PSUM_W  = 22;
  localparam int unsigned START_W = 20;
  localparam int unsigned SCORE_W = 23;
  localparam int unsigned NORM_W  = 17;
  localparam int unsigned MLEN_W  = 6;
  localparam int unsigned OFFS_W  = 8;
  localparam int unsigned BASE_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BASE = 1'b1;

  typedef struct packed {
    logic              en;
    logic [1:0]        base;
    logic [COST_W-1:0] cost;
  } pms_wr_t;

  typedef struct packed {
    logic               hit;
    logic [START_W-1:0] window_start;
  } pms_win_t;

endpackage

/* hdl/pwm_motif_scanner_core.sv */
// Top level of the position weight matrix scanner.
`timescale 1ns / 1ps
`include "pwm_motif_scanner_core_defines.svh"
// Scores a base stream against one weight matrix held in a chain of MAX_MOTIF
// cells, each keeping the four costs of its position and one partial sum.
// Load cost words first (opcode 0), then stream base words (opcode 1); every
// base shifts all partial sums one cell down the chain in the same cycle.
// One word is taken per cycle while in_stall is low. A score passes from its
// base word through the chain update, which also loads the tap stage, then
// through the tap select of the partial sum at motif_length-1 and the
// normalizer add into the output register. The input stalls only while a
// score waits in the tap stage and the output register is full and stalled.
// Cost entries read before they are written give undefined scores.
module pwm_motif_scanner_core #(
  parameter int unsigned MAX_MOTIF  = pms_pkg::MAX_MOTIF_DEF,
  parameter int unsigned INDEX_BITS = pms_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [pms_pkg::BASE_W-1:0]    in_base_code,
  input  logic [pms_pkg::POS_W-1:0]     in_motif_position,
  input  logic [pms_pkg::COST_W-1:0]    in_weight_cost,
  input  logic                          in_sequence_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pms_pkg::START_W-1:0]   out_window_start,
  output logic signed [pms_pkg::SCORE_W-1:0] out_score,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pms_pkg::ADDR_W-1:0]    paddr,
  input  logic [pms_pkg::DATA_W-1:0]    pwdata,
  output logic [pms_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned TAP_W = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

  localparam logic [1:0] REG_MOTIF_LENGTH = 2'd0;
  localparam logic [1:0] REG_START_OFFSET = 2'd1;
  localparam logic [1:0] REG_LOG2_NORM    = 2'd2;

  logic [pms_pkg::MLEN_W-1:0] motif_length_r;
  logic [pms_pkg::OFFS_W-1:0] start_offset_r;
  logic [pms_pkg::NORM_W-1:0] log2_norm_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_sel;

  logic in_acc;
  logic step;
  logic out_adv;
  logic p1_en;

  pms_pkg::pms_win_t win;
  logic [TAP_W-1:0]  tap;

  logic [pms_pkg::PSUM_W-1:0] psum [MAX_MOTIF];
  logic [pms_pkg::PSUM_W-1:0] link [MAX_MOTIF];

  logic                        p1_r;
  logic [pms_pkg::START_W-1:0] p1_ws_r;
  logic [TAP_W-1:0]            p1_tap_r;

  logic                        out_valid_r;
  logic [pms_pkg::START_W-1:0] out_ws_r;
  logic [pms_pkg::SCORE_W-1:0] out_score_r;
  logic [pms_pkg::SCORE_W-1:0] score_nxt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_length_r <= pms_pkg::MLEN_W'(1);
      start_offset_r <= '0;
      log2_norm_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_MOTIF_LENGTH: motif_length_r <= pwdata[pms_pkg::MLEN_W-1:0];
        REG_START_OFFSET: start_offset_r <= pwdata[pms_pkg::OFFS_W-1:0];
        REG_LOG2_NORM:    log2_norm_r    <= pwdata[pms_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MOTIF_LENGTH: prdata = pms_pkg::DATA_W'(motif_length_r);
      REG_START_OFFSET: prdata = pms_pkg::DATA_W'(start_offset_r);
      REG_LOG2_NORM:    prdata = {{(pms_pkg::DATA_W - pms_pkg::NORM_W){log2_norm_r[16]}},
                                  log2_norm_r};
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign out_adv  = !out_valid_r || !out_stall;
  assign p1_en    = !p1_r || out_adv;
  assign in_stall = p1_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;
  assign step     = in_acc && (in_opcode == pms_pkg::OP_BASE);

  // cell chain
  for (genvar j = 0; j < MAX_MOTIF; j++) begin : g_cell
    pms_pkg::pms_wr_t wr;

    assign wr.en   = in_acc && (in_opcode == pms_pkg::OP_LOAD) && !in_base_code[2] &&
                     (32'(in_motif_position) == 32'(j));
    assign wr.base = in_base_code[1:0];
    assign wr.cost = in_weight_cost;

    if (j == 0) begin : g_head
      assign link[j] = '0;
    end else begin : g_link
      assign link[j] = psum[j-1];
    end

    pms_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (step),
      .base_code (in_base_code),
      .wr        (wr),
      .psum_in   (link[j]),
      .psum_out  (psum[j])
    );
  end

  pms_ctrl #(
    .MAX_MOTIF  (MAX_MOTIF),
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .seq_start    (in_sequence_start),
    .motif_length (motif_length_r),
    .start_offset (start_offset_r),
    .win          (win),
    .tap          (tap)
  );

  // tap stage: hold until the output register frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
    end else if (p1_en) begin
      p1_r <= win.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_en) begin
      p1_ws_r  <= win.window_start;
      p1_tap_r <= tap;
    end
  end

  assign score_nxt = pms_pkg::SCORE_W'(psum[p1_tap_r]) +
                     {{(pms_pkg::SCORE_W - pms_pkg::NORM_W){log2_norm_r[16]}}, log2_norm_r};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p1_r) begin
      out_ws_r    <= p1_ws_r;
      out_score_r <= score_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_start = out_ws_r;
  assign out_score        = out_score_r;

  `PMS_ASSERT_NEXT(a_hit_reaches_tap, win.hit, p1_r, "scored base word did not reach tap stage")
  `PMS_ASSERT_NEXT(a_tap_holds, p1_r && !out_adv, p1_r && $stable(p1_tap_r), "tap stage lost a word")
  `PMS_ASSERT_NOW(a_out_from_tap, $rose(out_valid_r), $past(p1_r), "result without a tap word")

endmodule

/* hdl/pms_cell.sv */
// One motif position: its four base costs and its partial sum stage.
`timescale 1ns / 1ps
module pms_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic [pms_pkg::BASE_W-1:0] base_code,
  input  pms_pkg::pms_wr_t         wr,
  input  logic [pms_pkg::PSUM_W-1:0] psum_in,
  output logic [pms_pkg::PSUM_W-1:0] psum_out
);

  logic [pms_pkg::COST_W-1:0] cost_r [4];
  logic [pms_pkg::COST_W-1:0] cost_sel;
  logic [pms_pkg::PSUM_W-1:0] psum_r;
  logic [pms_pkg::PSUM_W-1:0] psum_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cost_r[wr.base] <= wr.cost;
    end
  end

  // non-ACGT codes cost nothing
  assign cost_sel = base_code[2] ? '0 : cost_r[base_code[1:0]];
  assign psum_nxt = psum_in + pms_pkg::PSUM_W'(cost_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
    end else if (shift_en) begin
      psum_r <= psum_nxt;
    end
  end

  assign psum_out = psum_r;

endmodule

/* hdl/pms_ctrl.sv */
// Base index, window fill and window decision for each base word.
`timescale 1ns / 1ps
module pms_ctrl #(
  parameter int unsigned MAX_MOTIF  = pms_pkg::MAX_MOTIF_DEF,
  parameter int unsigned INDEX_BITS = pms_pkg::INDEX_BITS_DEF,
  localparam int unsigned LEN_W = $clog2(MAX_MOTIF + 1),
  localparam int unsigned TAP_W = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       seq_start,
  input  logic [pms_pkg::MLEN_W-1:0] motif_length,
  input  logic [pms_pkg::OFFS_W-1:0] start_offset,
  output pms_pkg::pms_win_t          win,
  output logic [TAP_W-1:0]           tap
);

  logic [INDEX_BITS-1:0] base_index_r;
  logic [INDEX_BITS-1:0] base_index_nxt;
  logic [LEN_W-1:0]      fill_r;
  logic [LEN_W-1:0]      fill_nxt;
  logic [INDEX_BITS-1:0] idx;
  logic [LEN_W-1:0]      fill_cur;
  logic [LEN_W-1:0]      len;
  logic [INDEX_BITS-1:0] wstart;
  logic [31:0]           wstart_ext;

  always_comb begin
    if (motif_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(motif_length) > MAX_MOTIF) begin
      len = LEN_W'(MAX_MOTIF);
    end else begin
      len = LEN_W'(motif_length);
    end
  end

  assign idx            = seq_start ? '0 : base_index_r;
  assign fill_cur       = seq_start ? '0 : fill_r;
  assign base_index_nxt = idx + 1'b1;
  assign fill_nxt       = (32'(fill_cur) < MAX_MOTIF) ? fill_cur + 1'b1 : fill_cur;

  assign wstart     = idx - INDEX_BITS'(len - 1'b1);
  assign wstart_ext = 32'(wstart);

  assign win.hit          = step && (fill_nxt >= len) &&
                            (wstart_ext >= 32'(start_offset));
  assign win.window_start = wstart_ext[pms_pkg::START_W-1:0];
  assign tap              = TAP_W'(len - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_index_r <= '0;
      fill_r       <= '0;
    end else if (step) begin
      base_index_r <= base_index_nxt;
      fill_r       <= fill_nxt;
    end
  end

endmodule
